[hw/rtl/psi_pkg.sv]
// shared constants and types of the power spectrum integrator
`timescale 1ns / 1ps
`default_nettype none

package psi_pkg;

  // defaults of the top level parameters
  localparam int DEF_MAX_BINS    = 4096;
  localparam int DEF_PART_WIDTH  = 24;
  localparam int DEF_POWER_WIDTH = 48;

  // fixed field widths
  localparam int BIN_NUM_W = 12;
  localparam int FRAME_W   = 16;
  localparam int LOG2_W    = 4;
  localparam int SCALE_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  // q1.16 scale
  localparam int                 SCALE_SHIFT = 16;
  localparam logic [SCALE_W-1:0] SCALE_ONE   = 17'h10000;

  // bins_log2 range and reset
  localparam logic [LOG2_W-1:0] LOG2_MIN = 4'd4;
  localparam logic [LOG2_W-1:0] LOG2_MAX = 4'd12;
  localparam int                LOG2_RST = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BINS_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE  = 2'd2;

  // per-item control carried alongside the arithmetic pipeline
  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic                 first;     // first frame: overwrite the store entry
    logic                 emit;      // last frame: a result beat leaves
    logic                 last_bin;
  } ctl_t;

endpackage

`default_nettype wire

[hw/rtl/psi_intf.sv]
// channel interfaces of the power spectrum integrator
`timescale 1ns / 1ps
`default_nettype none

interface psi_in_if #(
  parameter int PART_WIDTH = psi_pkg::DEF_PART_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [PART_WIDTH-1:0] bin_real;
  logic signed [PART_WIDTH-1:0] bin_imag;

  modport source (output valid, bin_real, bin_imag, input ready);
  modport sink   (input valid, bin_real, bin_imag, output ready);
endinterface

interface psi_out_if #(
  parameter int POWER_WIDTH = psi_pkg::DEF_POWER_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [psi_pkg::BIN_NUM_W-1:0]  bin_number;
  logic [POWER_WIDTH-1:0]         power;
  logic                           last_bin;

  modport source (output valid, bin_number, power, last_bin, input ready);
  modport sink   (input valid, bin_number, power, last_bin, output ready);
endinterface

interface psi_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [psi_pkg::CFG_IDX_W-1:0] index;
  logic [psi_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/psi_power.sv]
// scale, square and sum of one bin, three register stages
`timescale 1ns / 1ps
`default_nettype none

module psi_power #(
  parameter int PART_WIDTH  = psi_pkg::DEF_PART_WIDTH,
  parameter int POWER_WIDTH = psi_pkg::DEF_POWER_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [PART_WIDTH-1:0]  bin_real,
  input  wire logic signed [PART_WIDTH-1:0]  bin_imag,
  input  wire logic [psi_pkg::SCALE_W-1:0]   scale,
  output logic [POWER_WIDTH-1:0]             power
);
  import psi_pkg::*;

  localparam int PROD_W = PART_WIDTH + SCALE_W + 1;
  localparam int SQ_W   = 2 * PART_WIDTH;
  localparam int SUM_W  = SQ_W + 1;
  localparam int EXT_W  = (SUM_W > POWER_WIDTH) ? SUM_W : POWER_WIDTH;
  localparam logic [POWER_WIDTH-1:0] PMAX = {POWER_WIDTH{1'b1}};

  logic signed [PROD_W-1:0]     prod_re;
  logic signed [PROD_W-1:0]     prod_im;
  logic signed [PART_WIDTH-1:0] sh_re;
  logic signed [PART_WIDTH-1:0] sh_im;
  logic signed [SQ_W-1:0]       ext_re;
  logic signed [SQ_W-1:0]       ext_im;
  logic [SQ_W-1:0]              sq_re;
  logic [SQ_W-1:0]              sq_im;
  logic [EXT_W-1:0]             sum;

  // floor shift; scale <= 1.0 keeps the result inside the part range
  assign sh_re  = PART_WIDTH'(prod_re >>> SCALE_SHIFT);
  assign sh_im  = PART_WIDTH'(prod_im >>> SCALE_SHIFT);
  assign ext_re = SQ_W'(sh_re);
  assign ext_im = SQ_W'(sh_im);
  assign sum    = EXT_W'(sq_re) + EXT_W'(sq_im);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_re <= PROD_W'(bin_real) * $signed({1'b0, scale});
      prod_im <= PROD_W'(bin_imag) * $signed({1'b0, scale});
      sq_re   <= ext_re * ext_re;
      sq_im   <= ext_im * ext_im;
      power   <= (sum > EXT_W'(PMAX)) ? PMAX : POWER_WIDTH'(sum);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/power_spectrum_integrator_core.sv]
// top level of the power spectrum integrator
`timescale 1ns / 1ps
`default_nettype none

// channel    role     beat
// fft        sink     bin_real, bin_imag of the next bin in bin order
// spectrum   source   bin_number, power, last_bin of a finished bin
// cfg        sink     index, data of a register write (always ready)
//
// one bin a cycle while spectrum is not stalled; a result beat is registered after its bin
// is taken (multiply, square, sum and store read, accumulate into the result register)
// reset clears the counters and loads the register defaults; the store is
// not cleared, the first frame of each integration overwrites it
// a result left waiting on spectrum holds the whole pipeline and fft.ready

module power_spectrum_integrator_core #(
  parameter int MAX_BINS    = psi_pkg::DEF_MAX_BINS,    // power of two
  parameter int PART_WIDTH  = psi_pkg::DEF_PART_WIDTH,
  parameter int POWER_WIDTH = psi_pkg::DEF_POWER_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  psi_in_if.sink   fft,
  psi_out_if.source spectrum,
  psi_cfg_if.sink  cfg
);
  import psi_pkg::*;

  localparam int ADDR_W   = $clog2(MAX_BINS);
  localparam int NB_RST   = ((1 << LOG2_RST) < MAX_BINS) ? (1 << LOG2_RST) : MAX_BINS;
  localparam logic [BIN_NUM_W-1:0] LAST_IDX_RST = BIN_NUM_W'(NB_RST - 1);
  localparam int NB_W     = BIN_NUM_W + 1;
  // largest frame the bin counter and the store can both hold
  localparam int NB_CAP   = (MAX_BINS < (1 << BIN_NUM_W)) ? MAX_BINS : (1 << BIN_NUM_W);

  // configuration, held in the form the datapath uses
  logic [BIN_NUM_W-1:0] last_idx;    // bins in use minus one
  logic [FRAME_W-1:0]   frames_m1;   // frames per integration minus one
  logic [SCALE_W-1:0]   scale;       // clamped to 1.0

  // write-time conversion of the register values
  logic [LOG2_W-1:0]    lg;
  logic [NB_W-1:0]      nbins;
  logic [FRAME_W-1:0]   frames_w;

  logic [BIN_NUM_W-1:0] bin_counter;
  logic [FRAME_W-1:0]   frame_counter;

  logic adv;
  logic take;
  logic last_bin;
  logic last_frame;
  ctl_t ctl_in;
  ctl_t ctl_a;
  ctl_t ctl_b;
  ctl_t ctl_c;
  logic va;
  logic vb;
  logic vc;

  logic [POWER_WIDTH-1:0] store [MAX_BINS];
  logic [POWER_WIDTH-1:0] rd_data;
  logic [POWER_WIDTH-1:0] p;
  logic [POWER_WIDTH:0]   acc_sum;
  logic [POWER_WIDTH-1:0] acc;
  logic [ADDR_W-1:0]      addr_b;
  logic [ADDR_W-1:0]      addr_c;

  // ---------------- configuration port ----------------
  assign cfg.ready = 1'b1;

  always_comb begin
    lg = cfg.data[LOG2_W-1:0];
    if (lg < LOG2_MIN) begin
      lg = LOG2_MIN;
    end else if (lg > LOG2_MAX) begin
      lg = LOG2_MAX;
    end
    nbins = NB_W'(1) << lg;
    if (nbins > NB_W'(NB_CAP)) begin
      nbins = NB_W'(NB_CAP);
    end
    frames_w = cfg.data[FRAME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx  <= LAST_IDX_RST;
      frames_m1 <= '0;
      scale     <= SCALE_ONE;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BINS_LOG2: last_idx  <= BIN_NUM_W'(nbins - NB_W'(1));
        REG_FRAMES:    frames_m1 <= (frames_w == '0) ? '0 : frames_w - FRAME_W'(1);
        REG_INV_SCALE: scale     <= (cfg.data > SCALE_ONE) ? SCALE_ONE : cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- bin and frame counters ----------------
  // the whole pipeline moves unless a result waits on a stalled sink
  assign adv       = !spectrum.valid || spectrum.ready;
  assign fft.ready = adv;
  assign take      = fft.valid && adv;

  // a counter past the end after a register change still ends its frame
  assign last_bin   = bin_counter >= last_idx;
  assign last_frame = frame_counter >= frames_m1;

  always_comb begin
    ctl_in.bin_number = bin_counter;
    ctl_in.first      = frame_counter == '0;
    ctl_in.emit       = last_frame;
    ctl_in.last_bin   = last_bin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter   <= '0;
      frame_counter <= '0;
    end else if (take) begin
      if (last_bin) begin
        bin_counter   <= '0;
        frame_counter <= last_frame ? '0 : frame_counter + FRAME_W'(1);
      end else begin
        bin_counter <= bin_counter + BIN_NUM_W'(1);
      end
    end
  end

  // ---------------- arithmetic pipeline ----------------
  psi_power #(
    .PART_WIDTH  (PART_WIDTH),
    .POWER_WIDTH (POWER_WIDTH)
  ) u_power (
    .clk      (clk),
    .en       (adv),
    .bin_real (fft.bin_real),
    .bin_imag (fft.bin_imag),
    .scale    (scale),
    .power    (p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      va <= take;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_a <= ctl_in;
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
    end
  end

  // ---------------- power store, read-modify-write ----------------
  // a bin comes back only after at least fifteen others, so the read of
  // one item never meets the pending write of another to the same entry
  assign addr_b = ADDR_W'(ctl_b.bin_number);
  assign addr_c = ADDR_W'(ctl_c.bin_number);

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= store[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vc) begin
      store[addr_c] <= acc;
    end
  end

  // saturating accumulate, overwrite in the first frame
  assign acc_sum = {1'b0, rd_data} + {1'b0, p};

  always_comb begin
    if (ctl_c.first) begin
      acc = p;
    end else if (acc_sum[POWER_WIDTH]) begin
      acc = '1;
    end else begin
      acc = acc_sum[POWER_WIDTH-1:0];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      spectrum.valid <= 1'b0;
    end else if (adv) begin
      spectrum.valid <= vc && ctl_c.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vc && ctl_c.emit) begin
      spectrum.bin_number <= ctl_c.bin_number;
      spectrum.power      <= acc;
      spectrum.last_bin   <= ctl_c.last_bin;
    end
  end

endmodule

`default_nettype wire
